// ===== hdl/kogg_pkg.sv =====
// ----------------------------------------------------------------------------
// kogg_pkg
// Shared widths, codes and constant tables for the Klopman-Ohno gamma and
// gradient pair block.
// ----------------------------------------------------------------------------
package kogg_pkg;

	localparam int MAX_ATOMS = 64;
	localparam int IDX_W     = $clog2(MAX_ATOMS);
	localparam int ATOM_W    = 6;
	localparam int DISP_W    = 33;
	localparam int Q_W       = 32;
	localparam int ACC_W     = 48;
	localparam int LOG_F     = 24;   // fraction bits of a log2 value
	localparam int LW_W      = 42;   // width of a log2 value
	localparam int DIV_STEPS = 53;   // quotient bits of (t << 28) / alpha

	localparam logic [31:0] ALPHA_RESET = 32'h2000_0000;  // 2.0 in Q4.28

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COINC = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef logic [LOG_F:0][31:0] pow_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem   = val;
		res   = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// entry k holds 2^(2^-k) with 30 fraction bits, entry 0 is 2.0
	function automatic pow_tab_t build_pow_tab();
		pow_tab_t tab;
		tab[0] = 32'h8000_0000;
		for (int k = 1; k <= LOG_F; k++) begin
			tab[k] = 32'(isqrt64({32'b0, tab[k-1]} << 30));
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// ===== hdl/klopman_ohno_gamma_gradient_pair_top.sv =====
// ----------------------------------------------------------------------------
// klopman_ohno_gamma_gradient_pair_top
// Klopman-Ohno shell-pair gamma with gradient accumulation per atom.
// ----------------------------------------------------------------------------
// One item is an ordered shell pair. The block forms gij = (h1 + h2) / 2 and,
// for shells on different atoms, gamma = (R^a + gij^-a)^(-1/a) with all powers
// worked in the log2 domain (24 fraction bits), then adds
// -q1*q2*R^(a-2)*gamma^(a+1)*d to the x, y and z gradient accumulators of the
// first atom (Q16.32, saturating) and returns gamma and the three updated
// accumulators. Same-atom pairs return gij and leave the gradient alone;
// coincident distinct atoms return gij with status 1; a clamp gives status 2.
// clear_first zeroes the first atom's accumulators before this pair, in every
// case. All products share one 32x32 multiplier under a sequencer: a log2 is
// a normalize followed by squaring steps, a 2^x is a run of table multiplies,
// alpha products take a multiply state and a shift state, and the division by
// alpha is a bit-serial restoring divider. A same-atom or skipped pair goes
// from the load state straight to the output state. The block takes one item
// at a time: in_ready is high only while idle. A result sits in the output
// register until taken, and the next item may be accepted meanwhile. alpha is
// written over the cfg port, which is always ready; a value of zero acts as one
// LSB. The accumulators sit in a 64-entry memory with a valid bit per entry,
// so reset clears them at once.
module klopman_ohno_gamma_gradient_pair_top
	import kogg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// input items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ATOM_W-1:0]        atom_first,
	input  logic [ATOM_W-1:0]        atom_second,
	input  logic signed [DISP_W-1:0] disp_x,
	input  logic signed [DISP_W-1:0] disp_y,
	input  logic signed [DISP_W-1:0] disp_z,
	input  logic [31:0]              hardness_first,
	input  logic [31:0]              hardness_second,
	input  logic signed [Q_W-1:0]    charge_first,
	input  logic signed [Q_W-1:0]    charge_second,
	input  logic                     clear_first,
	// result items
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              gamma_value,
	output logic signed [ACC_W-1:0]  grad_x,
	output logic signed [ACC_W-1:0]  grad_y,
	output logic signed [ACC_W-1:0]  grad_z,
	output logic [1:0]               status,
	// alpha register write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [31:0]              cfg_data
);

	// sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LOAD  = 5'd1;
	localparam logic [4:0] S_SQ    = 5'd2;
	localparam logic [4:0] S_X     = 5'd3;
	localparam logic [4:0] S_LNORM = 5'd4;
	localparam logic [4:0] S_LSQ   = 5'd5;
	localparam logic [4:0] S_EMUL  = 5'd6;
	localparam logic [4:0] S_MQ0   = 5'd7;
	localparam logic [4:0] S_MQ1   = 5'd8;
	localparam logic [4:0] S_LR    = 5'd9;
	localparam logic [4:0] S_LG    = 5'd10;
	localparam logic [4:0] S_W     = 5'd11;
	localparam logic [4:0] S_E     = 5'd12;
	localparam logic [4:0] S_T     = 5'd13;
	localparam logic [4:0] S_DIV   = 5'd14;
	localparam logic [4:0] S_Q     = 5'd15;
	localparam logic [4:0] S_G     = 5'd16;
	localparam logic [4:0] S_P1    = 5'd17;
	localparam logic [4:0] S_P2    = 5'd18;
	localparam logic [4:0] S_L1    = 5'd19;
	localparam logic [4:0] S_L2    = 5'd20;
	localparam logic [4:0] S_AX    = 5'd21;
	localparam logic [4:0] S_AXL   = 5'd22;
	localparam logic [4:0] S_AXE   = 5'd23;
	localparam logic [4:0] S_DONE  = 5'd24;

	// 2^x output caps
	localparam logic [1:0] EM_ONE30 = 2'd0;
	localparam logic [1:0] EM_M32   = 2'd1;
	localparam logic [1:0] EM_B48   = 2'd2;

	localparam logic signed [LW_W-1:0] LOG_CLAMP = LW_W'(64 * (1 << LOG_F));
	localparam logic signed [ACC_W:0]  ACC_HI = {2'b00, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W:0]  ACC_LO = {2'b11, {(ACC_W-1){1'b0}}};
	localparam logic [ACC_W:0]         NEG_LIM = {2'b01, {(ACC_W-1){1'b0}}};

	// control
	logic [4:0]            state_q;
	logic [4:0]            ret_q;
	logic [5:0]            cnt_q;
	logic [1:0]            axis_q;
	logic [31:0]           alpha_q;
	logic [MAX_ATOMS-1:0]  valid_q;
	logic                  rdv_q;
	logic                  out_valid_q;

	// item
	logic [ATOM_W-1:0]        a1_q;
	logic [ATOM_W-1:0]        a2_q;
	logic signed [DISP_W-1:0] dx_q;
	logic signed [DISP_W-1:0] dy_q;
	logic signed [DISP_W-1:0] dz_q;
	logic [31:0]              h1_q;
	logic [31:0]              h2_q;
	logic signed [Q_W-1:0]    q1_q;
	logic signed [Q_W-1:0]    q2_q;
	logic                     clr_q;

	// datapath
	logic [3*ACC_W-1:0]      acc_mem [MAX_ATOMS];
	logic [3*ACC_W-1:0]      rd_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic [1:0]              stat_q;
	logic [31:0]             gamma_q;
	logic [63:0]             mult_q;
	logic [65:0]             sum_q;
	logic [63:0]             xn_q;
	logic [5:0]              sh_q;
	logic [5:0]              lfb_q;
	logic [22:0]             frac_q;
	logic signed [LW_W-1:0]  log_q;
	logic signed [LW_W-1:0]  el_q;
	logic [5:0]              ef_q;
	logic [1:0]              em_q;
	logic [ACC_W:0]          exp_q;
	logic signed [33:0]      mq_c_q;
	logic signed [LW_W-1:0]  mq_l_q;
	logic signed [LW_W-1:0]  mq_q;
	logic signed [LW_W-1:0]  lr_q;
	logic signed [LW_W-1:0]  lg_q;
	logic signed [LW_W-1:0]  lgm_q;
	logic signed [LW_W-1:0]  p_q;
	logic [DIV_STEPS-1:0]    dq_q;
	logic [31:0]             rem_q;

	// output register
	logic [31:0]             gamma_out_q;
	logic signed [ACC_W-1:0] gx_out_q;
	logic signed [ACC_W-1:0] gy_out_q;
	logic signed [ACC_W-1:0] gz_out_q;
	logic [1:0]              stat_out_q;

	// combinational
	logic [DISP_W-1:0]       dm [3];
	logic                    dn [3];
	logic [Q_W-1:0]          q1m;
	logic [Q_W-1:0]          q2m;
	logic [31:0]             gij;
	logic [31:0]             a_eff;
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [DISP_W-1:0]       sq_prev;
	logic [65:0]             sq_term;
	logic [30:0]             mm_l;
	logic [7:0]              intp;
	logic signed [LW_W-1:0]  log_new;
	logic [LOG_F-1:0]        e_shift;
	logic [4:0]              tab_idx;
	logic [31:0]             mm_e;
	logic signed [LW_W-1:0]  e_s;
	logic signed [LW_W-1:0]  e_neg;
	logic [63:0]             e_up;
	logic [63:0]             e_dn;
	logic [63:0]             e_max;
	logic [63:0]             e_v;
	logic [33:0]             mc_abs;
	logic [LW_W-1:0]         ml_abs;
	logic [64:0]             mq_prod;
	logic signed [65:0]      mq_sp;
	logic signed [65:0]      mq_sh;
	logic signed [LW_W-1:0]  sm_raw;
	logic signed [LW_W-1:0]  sm;
	logic [32:0]             div_r;
	logic                    div_ge;
	logic signed [LW_W-1:0]  q_cl;
	logic signed [LW_W-1:0]  mn;
	logic signed [LW_W-1:0]  lgm_raw;
	logic [DISP_W-1:0]       dm_ax;
	logic                    dn_ax;
	logic                    ax_neg;
	logic signed [ACC_W:0]   contrib;
	logic                    contrib_sat;
	logic signed [ACC_W:0]   acc_sum;
	logic                    mem_we;
	logic                    in_fire;

	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign gamma_value = gamma_out_q;
	assign grad_x      = gx_out_q;
	assign grad_y      = gy_out_q;
	assign grad_z      = gz_out_q;
	assign status      = stat_out_q;
	assign mem_we      = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		// operand magnitudes and signs
		dm[0] = dx_q[DISP_W-1] ? DISP_W'(-dx_q) : DISP_W'(dx_q);
		dm[1] = dy_q[DISP_W-1] ? DISP_W'(-dy_q) : DISP_W'(dy_q);
		dm[2] = dz_q[DISP_W-1] ? DISP_W'(-dz_q) : DISP_W'(dz_q);
		dn[0] = dx_q[DISP_W-1];
		dn[1] = dy_q[DISP_W-1];
		dn[2] = dz_q[DISP_W-1];
		q1m   = q1_q[Q_W-1] ? Q_W'(-q1_q) : Q_W'(q1_q);
		q2m   = q2_q[Q_W-1] ? Q_W'(-q2_q) : Q_W'(q2_q);
		gij   = 32'(({1'b0, h1_q} + {1'b0, h2_q}) >> 1);
		a_eff = (alpha_q == '0) ? 32'd1 : alpha_q;

		// sum of squares
		case (cnt_q[1:0])
			2'd1:    sq_prev = dm[0];
			2'd2:    sq_prev = dm[1];
			default: sq_prev = dm[2];
		endcase
		sq_term = sq_prev[DISP_W-1] ? {2'b01, 64'b0} : {2'b00, mult_q};

		// log2: squaring of the 1.30 mantissa
		mm_l    = (cnt_q == '0) ? xn_q[63:33]
			: (mult_q[61] ? mult_q[61:31] : mult_q[60:30]);
		intp    = 8'(7'd63 - {1'b0, sh_q}) - {2'b00, lfb_q};
		log_new = {{(LW_W-LOG_F-8){intp[7]}}, intp, frac_q, mult_q[61]};

		// 2^x: product over the table, then shift and cap
		e_shift = el_q[LOG_F-1:0] << cnt_q[4:0];
		tab_idx = (cnt_q < 6'(LOG_F)) ? (cnt_q[4:0] + 5'd1) : 5'd0;
		mm_e    = (cnt_q == '0) ? 32'h4000_0000 : mult_q[61:30];
		e_s     = (el_q >>> LOG_F) + $signed({{(LW_W-6){1'b0}}, ef_q}) - LW_W'(30);
		e_neg   = -e_s;
		e_up    = {32'b0, mult_q[61:30]} << e_s[5:0];
		e_dn    = {32'b0, mult_q[61:30]} >> e_neg[5:0];
		case (em_q)
			EM_ONE30: e_max = 64'h4000_0000;
			EM_M32:   e_max = 64'hFFFF_FFFF;
			default:  e_max = 64'h1_0000_0000_0000;
		endcase
		if (e_s >= LW_W'(33)) begin
			e_v = e_max;
		end else if (e_s >= 0) begin
			e_v = (e_up > e_max) ? e_max : e_up;
		end else if (e_s <= -LW_W'(32)) begin
			e_v = '0;
		end else begin
			e_v = (e_dn > e_max) ? e_max : e_dn;
		end

		// Q4.28 factor times log, floored
		mc_abs  = mq_c_q[33] ? 34'(-mq_c_q) : 34'(mq_c_q);
		ml_abs  = mq_l_q[LW_W-1] ? LW_W'(-mq_l_q) : LW_W'(mq_l_q);
		mq_prod = {1'b0, mult_q} + (mc_abs[32] ? {1'b0, ml_abs[31:0], 32'b0} : 65'd0);
		mq_sp   = (mq_c_q[33] ^ mq_l_q[LW_W-1]) ? -$signed({1'b0, mq_prod})
			: $signed({1'b0, mq_prod});
		mq_sh   = mq_sp >>> 28;

		sm_raw = lr_q + log_q;
		sm     = sm_raw[LW_W-1] ? -sm_raw : sm_raw;

		// restoring divide step
		div_r  = {rem_q, dq_q[DIV_STEPS-1]};
		div_ge = (div_r >= {1'b0, a_eff});

		q_cl    = (dq_q > DIV_STEPS'(LOG_CLAMP)) ? LOG_CLAMP
			: $signed({{(LW_W-31){1'b0}}, dq_q[30:0]});
		mn      = (-lr_q < lg_q) ? -lr_q : lg_q;
		lgm_raw = mn - q_cl;

		// per-axis contribution
		case (axis_q)
			2'd0:    begin dm_ax = dm[0]; dn_ax = dn[0]; end
			2'd1:    begin dm_ax = dm[1]; dn_ax = dn[1]; end
			default: begin dm_ax = dm[2]; dn_ax = dn[2]; end
		endcase
		ax_neg      = !(q1_q[Q_W-1] ^ q2_q[Q_W-1] ^ dn_ax);
		contrib_sat = 1'b0;
		if (!ax_neg) begin
			if (exp_q > ACC_HI) begin
				contrib     = ACC_HI;
				contrib_sat = 1'b1;
			end else begin
				contrib = $signed(exp_q);
			end
		end else begin
			if (exp_q > NEG_LIM) begin
				contrib     = ACC_LO;
				contrib_sat = 1'b1;
			end else begin
				contrib = -$signed(exp_q);
			end
		end
		acc_sum = $signed({acc_q[axis_q][ACC_W-1], acc_q[axis_q]}) + contrib;

		// shared multiplier operands
		case (state_q)
			S_SQ: begin
				case (cnt_q[1:0])
					2'd0:    mul_a = dm[0][31:0];
					2'd1:    mul_a = dm[1][31:0];
					default: mul_a = dm[2][31:0];
				endcase
				mul_b = mul_a;
			end
			S_LSQ: begin
				mul_a = {1'b0, mm_l};
				mul_b = {1'b0, mm_l};
			end
			S_EMUL: begin
				mul_a = mm_e;
				mul_b = e_shift[LOG_F-1] ? POW_TAB[tab_idx] : 32'h4000_0000;
			end
			S_MQ0: begin
				mul_a = mc_abs[31:0];
				mul_b = ml_abs[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// accumulator memory
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q <= acc_mem[atom_first[IDX_W-1:0]];
		end
		if (mem_we) begin
			acc_mem[a1_q[IDX_W-1:0]] <= {acc_q[2], acc_q[1], acc_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= '0;
			axis_q      <= '0;
			alpha_q     <= ALPHA_RESET;
			valid_q     <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
			a1_q        <= '0;
			a2_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			dz_q        <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			q1_q        <= '0;
			q2_q        <= '0;
			clr_q       <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
			stat_q      <= ST_OK;
			gamma_q     <= '0;
			mult_q      <= '0;
			sum_q       <= '0;
			xn_q        <= '0;
			sh_q        <= '0;
			lfb_q       <= '0;
			frac_q      <= '0;
			log_q       <= '0;
			el_q        <= '0;
			ef_q        <= '0;
			em_q        <= EM_ONE30;
			exp_q       <= '0;
			mq_c_q      <= '0;
			mq_l_q      <= '0;
			mq_q        <= '0;
			lr_q        <= '0;
			lg_q        <= '0;
			lgm_q       <= '0;
			p_q         <= '0;
			dq_q        <= '0;
			rem_q       <= '0;
			gamma_out_q <= '0;
			gx_out_q    <= '0;
			gy_out_q    <= '0;
			gz_out_q    <= '0;
			stat_out_q  <= ST_OK;
		end else begin
			mult_q <= mul_a * mul_b;

			if (cfg_valid) begin
				alpha_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						a1_q    <= atom_first;
						a2_q    <= atom_second;
						dx_q    <= disp_x;
						dy_q    <= disp_y;
						dz_q    <= disp_z;
						h1_q    <= hardness_first;
						h2_q    <= hardness_second;
						q1_q    <= charge_first;
						q2_q    <= charge_second;
						clr_q   <= clear_first;
						rdv_q   <= valid_q[atom_first[IDX_W-1:0]];
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					for (int k = 0; k < 3; k++) begin
						acc_q[k] <= (clr_q || !rdv_q) ? '0 : rd_q[k*ACC_W +: ACC_W];
					end
					gamma_q <= gij;
					stat_q  <= ST_OK;
					cnt_q   <= '0;
					sum_q   <= '0;
					if (a1_q == a2_q) begin
						state_q <= S_DONE;
					end else if (dm[0] == '0 && dm[1] == '0 && dm[2] == '0) begin
						stat_q  <= ST_COINC;
						state_q <= S_DONE;
					end else if (gij == '0) begin
						gamma_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q != '0) begin
						sum_q <= sum_q + sq_term;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						state_q <= S_X;
					end
				end
				S_X: begin
					// 66-bit sum taken to 64 bits by dropping two bits
					xn_q    <= (sum_q[65:64] != '0) ? sum_q[65:2] : sum_q[63:0];
					lfb_q   <= (sum_q[65:64] != '0) ? 6'd38 : 6'd40;
					sh_q    <= '0;
					cnt_q   <= '0;
					ret_q   <= S_LR;
					state_q <= S_LNORM;
				end
				S_LNORM: begin
					if ((xn_q & ~(64'hFFFF_FFFF_FFFF_FFFF >> (6'd32 >> cnt_q))) == '0) begin
						xn_q <= xn_q << (6'd32 >> cnt_q);
						sh_q <= sh_q + (6'd32 >> cnt_q);
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd5) begin
						cnt_q   <= '0;
						state_q <= S_LSQ;
					end
				end
				S_LSQ: begin
					if (cnt_q != '0) begin
						frac_q <= {frac_q[21:0], mult_q[61]};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(LOG_F)) begin
						log_q   <= log_new;
						state_q <= ret_q;
					end
				end
				S_EMUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(LOG_F)) begin
						exp_q   <= e_v[ACC_W:0];
						state_q <= ret_q;
					end
				end
				S_MQ0: begin
					state_q <= S_MQ1;
				end
				S_MQ1: begin
					mq_q    <= mq_sh[LW_W-1:0];
					state_q <= ret_q;
				end
				S_LR: begin
					lr_q    <= log_q >>> 1;
					xn_q    <= {32'b0, gij};
					lfb_q   <= 6'd28;
					sh_q    <= '0;
					cnt_q   <= '0;
					ret_q   <= S_LG;
					state_q <= S_LNORM;
				end
				S_LG: begin
					lg_q    <= log_q;
					mq_c_q  <= $signed({2'b00, a_eff});
					mq_l_q  <= sm;
					ret_q   <= S_W;
					state_q <= S_MQ0;
				end
				S_W: begin
					el_q    <= -mq_q;
					ef_q    <= 6'd30;
					em_q    <= EM_ONE30;
					cnt_q   <= '0;
					ret_q   <= S_E;
					state_q <= S_EMUL;
				end
				S_E: begin
					// log2(1 + 2^-w), argument with 30 fraction bits
					xn_q    <= 64'h4000_0000 + {15'b0, exp_q};
					lfb_q   <= 6'd30;
					sh_q    <= '0;
					cnt_q   <= '0;
					ret_q   <= S_T;
					state_q <= S_LNORM;
				end
				S_T: begin
					dq_q    <= {log_q[LOG_F:0], 28'b0};
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_ge ? 32'(div_r - {1'b0, a_eff}) : div_r[31:0];
					dq_q  <= {dq_q[DIV_STEPS-2:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= S_Q;
					end
				end
				S_Q: begin
					lgm_q   <= (lgm_raw < -LOG_CLAMP) ? -LOG_CLAMP : lgm_raw;
					el_q    <= (lgm_raw < -LOG_CLAMP) ? -LOG_CLAMP : lgm_raw;
					ef_q    <= 6'd28;
					em_q    <= EM_M32;
					cnt_q   <= '0;
					ret_q   <= S_G;
					state_q <= S_EMUL;
				end
				S_G: begin
					gamma_q <= exp_q[31:0];
					mq_c_q  <= $signed({2'b00, a_eff}) - 34'sh2000_0000;
					mq_l_q  <= lr_q;
					ret_q   <= S_P1;
					state_q <= S_MQ0;
				end
				S_P1: begin
					p_q     <= mq_q;
					mq_c_q  <= $signed({2'b00, a_eff}) + 34'sh1000_0000;
					mq_l_q  <= lgm_q;
					ret_q   <= S_P2;
					state_q <= S_MQ0;
				end
				S_P2: begin
					p_q <= p_q + mq_q;
					if (q1m == '0 || q2m == '0) begin
						state_q <= S_DONE;
					end else begin
						xn_q    <= {32'b0, q1m};
						lfb_q   <= 6'd28;
						sh_q    <= '0;
						cnt_q   <= '0;
						ret_q   <= S_L1;
						state_q <= S_LNORM;
					end
				end
				S_L1: begin
					p_q     <= p_q + log_q;
					xn_q    <= {32'b0, q2m};
					lfb_q   <= 6'd28;
					sh_q    <= '0;
					cnt_q   <= '0;
					ret_q   <= S_L2;
					state_q <= S_LNORM;
				end
				S_L2: begin
					p_q     <= p_q + log_q;
					axis_q  <= '0;
					state_q <= S_AX;
				end
				S_AX: begin
					if (axis_q == 2'd3) begin
						state_q <= S_DONE;
					end else if (dm_ax == '0) begin
						axis_q <= axis_q + 2'd1;
					end else begin
						xn_q    <= {31'b0, dm_ax};
						lfb_q   <= 6'd20;
						sh_q    <= '0;
						cnt_q   <= '0;
						ret_q   <= S_AXL;
						state_q <= S_LNORM;
					end
				end
				S_AXL: begin
					el_q    <= p_q + log_q;
					ef_q    <= 6'd32;
					em_q    <= EM_B48;
					cnt_q   <= '0;
					ret_q   <= S_AXE;
					state_q <= S_EMUL;
				end
				S_AXE: begin
					if (acc_sum > ACC_HI) begin
						acc_q[axis_q] <= ACC_HI[ACC_W-1:0];
						stat_q        <= ST_SAT;
					end else if (acc_sum < ACC_LO) begin
						acc_q[axis_q] <= ACC_LO[ACC_W-1:0];
						stat_q        <= ST_SAT;
					end else begin
						acc_q[axis_q] <= acc_sum[ACC_W-1:0];
						if (contrib_sat) begin
							stat_q <= ST_SAT;
						end
					end
					axis_q  <= axis_q + 2'd1;
					state_q <= S_AX;
				end
				S_DONE: begin
					if (mem_we) begin
						valid_q[a1_q[IDX_W-1:0]] <= 1'b1;
						gamma_out_q <= gamma_q;
						gx_out_q    <= acc_q[0];
						gy_out_q    <= acc_q[1];
						gz_out_q    <= acc_q[2];
						stat_out_q  <= stat_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
